// ===== hdl/assert_macros.svh =====
// Assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_RST(name, clk, prop, msg)
`endif
`endif

// ===== hdl/cmta_pkg.sv =====
`default_nettype none
package cmta_pkg;
  localparam int COORD_BITS    = 16;
  localparam int MAX_FACE_SIZE = 2048;
  localparam int FACE_BITS     = $clog2(MAX_FACE_SIZE);
  localparam int SIZE_BITS     = 12;
  localparam int DEN_BITS      = COORD_BITS + 1;
  localparam int NUM_BITS      = DEN_BITS + FACE_BITS;
  localparam int TEX_BITS      = 22;
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    REG_MAP_ENABLE  = 2'd0,
    REG_FACE_WIDTH  = 2'd1,
    REG_FACE_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                 sky;
    logic [2:0]           face;
    logic [NUM_BITS-1:0]  nu;
    logic [NUM_BITS-1:0]  nv;
    logic [DEN_BITS-1:0]  den;
    logic [SIZE_BITS-1:0] wc;
  } work_t;

  typedef struct packed {
    logic                 sky;
    logic [2:0]           face;
    logic [NUM_BITS-1:0]  ru;
    logic [NUM_BITS-1:0]  rv;
    logic [DEN_BITS-1:0]  den;
    logic [FACE_BITS-1:0] qu;
    logic [FACE_BITS-1:0] qv;
    logic [SIZE_BITS-1:0] wc;
  } div_t;

  typedef struct packed {
    logic                 map_enable;
    logic [FACE_BITS-1:0] w_m1;
    logic [FACE_BITS-1:0] h_m1;
    logic [SIZE_BITS-1:0] wc;
  } size_cfg_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] r;
    r = s;
    if (s == '0) r = SIZE_BITS'(1);
    else if (s > SIZE_BITS'(MAX_FACE_SIZE)) r = SIZE_BITS'(MAX_FACE_SIZE);
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/cmta_front.sv =====
`default_nettype none
module cmta_front import cmta_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] dx,
  input  wire logic signed [COORD_BITS-1:0] dy,
  input  wire logic signed [COORD_BITS-1:0] dz,
  input  wire size_cfg_t                    cfg,
  output logic                              adv,
  output logic                              out_valid,
  output work_t                             out_item,
  input  wire logic                         q_full
);
  logic [COORD_BITS-1:0] ax, ay, az, m;
  logic [1:0] axis;
  logic neg;
  logic signed [DEN_BITS-1:0] u, v;

  logic s1_valid, s1_sky;
  logic [2:0] s1_face;
  logic signed [DEN_BITS-1:0] s1_u, s1_v;
  logic [COORD_BITS-1:0] s1_m;

  logic signed [DEN_BITS:0] su, sv;

  assign adv = !out_valid || !q_full;

  always_comb begin
    ax = dx[COORD_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay = dy[COORD_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    az = dz[COORD_BITS-1] ? COORD_BITS'(-dz) : COORD_BITS'(dz);
    axis = 2'd0;
    m = ax;
    if (ay > m) begin
      axis = 2'd1;
      m = ay;
    end
    if (az > m) begin
      axis = 2'd2;
      m = az;
    end
    case (axis)
      2'd0: begin
        neg = dx[COORD_BITS-1];
        u = DEN_BITS'(dz);
        v = DEN_BITS'(dy);
        if (neg) u = -u;
      end
      2'd1: begin
        neg = dy[COORD_BITS-1];
        u = DEN_BITS'(dx);
        v = DEN_BITS'(dz);
        if (neg) u = -u;
      end
      default: begin
        neg = dz[COORD_BITS-1];
        u = DEN_BITS'(dx);
        v = DEN_BITS'(dy);
        if (!neg && dz != '0) u = -u;
      end
    endcase
  end

  always_comb begin
    su = (DEN_BITS+1)'(s1_u) + $signed({2'b00, s1_m});
    sv = $signed({2'b00, s1_m}) - (DEN_BITS+1)'(s1_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
    if (adv) begin
      s1_sky  <= !cfg.map_enable || m == '0;
      s1_face <= {axis, neg};
      s1_u    <= u;
      s1_v    <= v;
      s1_m    <= m;
      out_item.wc <= cfg.wc;
      if (s1_sky) begin
        out_item.sky  <= 1'b1;
        out_item.face <= 3'd0;
        out_item.nu   <= '0;
        out_item.nv   <= '0;
        out_item.den  <= DEN_BITS'(1);
      end else begin
        out_item.sky  <= 1'b0;
        out_item.face <= s1_face;
        out_item.nu   <= NUM_BITS'(su[DEN_BITS-1:0]) * NUM_BITS'(cfg.w_m1);
        out_item.nv   <= NUM_BITS'(sv[DEN_BITS-1:0]) * NUM_BITS'(cfg.h_m1);
        out_item.den  <= {s1_m, 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/cmta_queue.sv =====
`default_nettype none
module cmta_queue import cmta_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t din,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output work_t      dout
);
  work_t mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wp, rp;
  logic [Q_PTR_BITS:0] count;
  logic do_push, do_pop;

  assign full    = count == (Q_PTR_BITS+1)'(Q_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      count <= count + (Q_PTR_BITS+1)'(do_push) - (Q_PTR_BITS+1)'(do_pop);
    end
    if (do_push) mem[wp] <= din;
  end
endmodule
`default_nettype wire

// ===== hdl/cmta_back.sv =====
`default_nettype none
module cmta_back import cmta_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire work_t           in_item,
  output logic                 adv,
  output logic                 empty,
  input  wire logic            pop,
  output logic                 use_sky,
  output logic [2:0]           face,
  output logic [FACE_BITS-1:0] column,
  output logic [FACE_BITS-1:0] row,
  output logic [TEX_BITS-1:0]  texel_index
);
  div_t st [FACE_BITS+1];
  div_t st_next [FACE_BITS+1];
  logic [FACE_BITS:0] vld;
  logic fin_valid;
  logic [NUM_BITS-1:0] du, dv;

  assign empty = !fin_valid;
  assign adv   = !fin_valid || pop;

  always_comb begin
    st_next[0] = '{sky: in_item.sky, face: in_item.face, ru: in_item.nu, rv: in_item.nv,
                   den: in_item.den, qu: '0, qv: '0, wc: in_item.wc};
    du = '0;
    dv = '0;
    for (int k = 0; k < FACE_BITS; k++) begin
      st_next[k+1] = st[k];
      du = NUM_BITS'(st[k].den) << (FACE_BITS - 1 - k);
      dv = du;
      if (st[k].ru >= du) begin
        st_next[k+1].ru = st[k].ru - du;
        st_next[k+1].qu[FACE_BITS-1-k] = 1'b1;
      end
      if (st[k].rv >= dv) begin
        st_next[k+1].rv = st[k].rv - dv;
        st_next[k+1].qv[FACE_BITS-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      fin_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[FACE_BITS-1:0], in_valid};
      fin_valid <= vld[FACE_BITS];
    end
    if (adv) begin
      for (int k = 0; k <= FACE_BITS; k++) st[k] <= st_next[k];
      use_sky     <= st[FACE_BITS].sky;
      face        <= st[FACE_BITS].face;
      column      <= st[FACE_BITS].qu;
      row         <= st[FACE_BITS].qv;
      texel_index <= TEX_BITS'(TEX_BITS'(st[FACE_BITS].qv) * TEX_BITS'(st[FACE_BITS].wc)
                     + TEX_BITS'(st[FACE_BITS].qu));
    end
  end
endmodule
`default_nettype wire

// ===== hdl/cube_map_texel_address.sv =====
// Cube-map face and texel addressing.
// Input queue side: push with dir_x/dir_y/dir_z; an item is taken when
// push is high and full is low. Result side: the oldest result sits on
// use_sky/face/column/row/texel_index while empty is low and leaves on pop.
// Configuration: cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; index 0 map_enable, 1 face_width, 2 face_height. Write only
// when no item is in flight.
// Path: the front stage registers s1 and out_item, the 4-entry middle queue,
// 11 divider stages (one quotient bit of column and row each) plus one
// output register with the texel multiply.
// Throughput: one item per cycle when not stalled; the front and back pipelines
// each move as a whole, decoupled by the middle queue.
// Reset empties all pipelines and the queue and clears the registers
// (map off, sizes zero). When pop stays low the back pipeline holds, the
// middle queue fills, and then full rises.
`default_nettype none
`include "assert_macros.svh"
module cube_map_texel_address import cmta_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] dir_x,
  input  wire logic signed [COORD_BITS-1:0] dir_y,
  input  wire logic signed [COORD_BITS-1:0] dir_z,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              use_sky,
  output logic [2:0]                        face,
  output logic [FACE_BITS-1:0]              column,
  output logic [FACE_BITS-1:0]              row,
  output logic [TEX_BITS-1:0]               texel_index,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [SIZE_BITS-1:0]         cfg_data
);
  logic map_enable;
  logic [SIZE_BITS-1:0] face_width, face_height, wcl, hcl;
  size_cfg_t cfg;
  logic f_adv, f_valid, q_full, q_empty, b_adv;
  work_t f_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_enable  <= 1'b0;
      face_width  <= '0;
      face_height <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_MAP_ENABLE:  map_enable  <= cfg_data[0];
        REG_FACE_WIDTH:  face_width  <= cfg_data;
        REG_FACE_HEIGHT: face_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wcl = clamp_size(face_width);
    hcl = clamp_size(face_height);
    cfg.map_enable = map_enable;
    cfg.wc   = wcl;
    cfg.w_m1 = FACE_BITS'(wcl - 1'b1);
    cfg.h_m1 = FACE_BITS'(hcl - 1'b1);
  end

  assign full = !f_adv;

  cmta_front u_front (
    .clk, .rst,
    .in_valid (push),
    .dx (dir_x), .dy (dir_y), .dz (dir_z),
    .cfg,
    .adv (f_adv),
    .out_valid (f_valid),
    .out_item (f_item),
    .q_full
  );

  cmta_queue u_queue (
    .clk, .rst,
    .push (f_valid),
    .din (f_item),
    .full (q_full),
    .pop (b_adv),
    .empty (q_empty),
    .dout (q_item)
  );

  cmta_back u_back (
    .clk, .rst,
    .in_valid (!q_empty),
    .in_item (q_item),
    .adv (b_adv),
    .empty,
    .pop,
    .use_sky, .face, .column, .row, .texel_index
  );

  `ASSERT_RST(a_rst_empty, clk, rst |=> empty, "results present after reset")
  `ASSERT_CLK(a_sky_zero, clk, rst, !empty && use_sky |-> face == 3'd0 && column == '0 && row == '0, "sky result not zero")
  `ASSERT_CLK(a_face_rng, clk, rst, !empty |-> face != 3'd6 && face != 3'd7, "face out of range")
  `ASSERT_CLK(a_hold, clk, rst, !empty && !pop |=> !empty && $stable(texel_index), "result lost while stalled")
endmodule
`default_nettype wire
